FILE: rtl/stscan_pkg.sv
// ----------------------------------------------------------------------------
// stscan_pkg
// Shared token kinds, keyword words, punctuator decode and the control word
// that travels with each step's token bundle from scanner to output stage.
// ----------------------------------------------------------------------------
package stscan_pkg;

    typedef logic [4:0] kind_t;

    localparam kind_t KIND_IDENT    = 5'd0;
    localparam kind_t KIND_INT      = 5'd1;
    localparam kind_t KIND_VOID     = 5'd2;
    localparam kind_t KIND_RETURN   = 5'd3;
    localparam kind_t KIND_STRKW    = 5'd4;
    localparam kind_t KIND_NUMBER   = 5'd5;
    localparam kind_t KIND_STRING   = 5'd6;
    localparam kind_t KIND_LPAREN   = 5'd7;
    localparam kind_t KIND_RPAREN   = 5'd8;
    localparam kind_t KIND_LBRACKET = 5'd9;
    localparam kind_t KIND_RBRACKET = 5'd10;
    localparam kind_t KIND_LBRACE   = 5'd11;
    localparam kind_t KIND_RBRACE   = 5'd12;
    localparam kind_t KIND_SEMI     = 5'd13;
    localparam kind_t KIND_COLON    = 5'd14;
    localparam kind_t KIND_PLUS     = 5'd15;
    localparam kind_t KIND_MINUS    = 5'd16;
    localparam kind_t KIND_STAR     = 5'd17;
    localparam kind_t KIND_DIVIDE   = 5'd18;
    localparam kind_t KIND_PERCENT  = 5'd19;
    localparam kind_t KIND_ASSIGN   = 5'd20;
    localparam kind_t KIND_AMP      = 5'd21;
    localparam kind_t KIND_PIPE     = 5'd22;
    localparam kind_t KIND_CARET    = 5'd23;
    localparam kind_t KIND_BANG     = 5'd24;
    localparam kind_t KIND_ERROR    = 5'd25;

    // keyword bytes packed first byte lowest
    localparam logic [47:0] WORD_INT    = 48'h0000_0074_6E69;
    localparam logic [47:0] WORD_VOID   = 48'h0000_6469_6F76;
    localparam logic [47:0] WORD_RETURN = 48'h6E72_7574_6572;
    localparam logic [47:0] WORD_STRING = 48'h676E_6972_7473;

    localparam int QUEUE_DEPTH = 4;
    localparam int QUEUE_PTR_W = 2;

    typedef struct packed {
        logic  has_a;
        logic  has_b;
        kind_t kind_a;
        kind_t kind_b;
    } tok_ctl_t;

    localparam int TOK_CTL_W = $bits(tok_ctl_t);

    function automatic kind_t word_kind(input logic [47:0] prefix, input logic len3,
                                        input logic len4, input logic len6);
        kind_t k;
        k = KIND_IDENT;
        if (len3 && prefix == WORD_INT) begin
            k = KIND_INT;
        end else if (len4 && prefix == WORD_VOID) begin
            k = KIND_VOID;
        end else if (len6 && prefix == WORD_RETURN) begin
            k = KIND_RETURN;
        end else if (len6 && prefix == WORD_STRING) begin
            k = KIND_STRKW;
        end
        return k;
    endfunction

    function automatic kind_t single_kind(input logic [7:0] c);
        kind_t k;
        unique case (c)
            8'h28:   k = KIND_LPAREN;
            8'h29:   k = KIND_RPAREN;
            8'h5B:   k = KIND_LBRACKET;
            8'h5D:   k = KIND_RBRACKET;
            8'h7B:   k = KIND_LBRACE;
            8'h7D:   k = KIND_RBRACE;
            8'h3B:   k = KIND_SEMI;
            8'h3A:   k = KIND_COLON;
            8'h2B:   k = KIND_PLUS;
            8'h2D:   k = KIND_MINUS;
            8'h2A:   k = KIND_STAR;
            8'h25:   k = KIND_PERCENT;
            8'h3D:   k = KIND_ASSIGN;
            8'h26:   k = KIND_AMP;
            8'h7C:   k = KIND_PIPE;
            8'h5E:   k = KIND_CARET;
            8'h21:   k = KIND_BANG;
            default: k = KIND_ERROR;
        endcase
        return k;
    endfunction

endpackage

FILE: rtl/stscan_front.sv
// ----------------------------------------------------------------------------
// stscan_front
// Scanner state machine: classifies each byte, tracks the pending token and
// produces a bundle of up to two finished tokens per accepted item.
// ----------------------------------------------------------------------------
module stscan_front #(
    parameter int LENGTH_BITS = 16,
    parameter int LINE_BITS   = 24
) (
    input  logic                       aclk,
    input  logic                       aresetn,
    input  logic                       accept,
    input  logic                       command,
    input  logic [7:0]                 char_byte,
    output logic                       push,
    output stscan_pkg::tok_ctl_t       push_ctl,
    output logic [31:0]                push_start_a,
    output logic [31:0]                push_start_b,
    output logic [LENGTH_BITS-1:0]     push_len_a,
    output logic [LINE_BITS-1:0]       push_line
);

    typedef enum logic [5:0] {
        MODE_IDLE    = 6'b000001,
        MODE_IDENT   = 6'b000010,
        MODE_NUMBER  = 6'b000100,
        MODE_STRING  = 6'b001000,
        MODE_SLASH   = 6'b010000,
        MODE_COMMENT = 6'b100000
    } mode_t;

    mode_t                  mode_reg, mode_next;
    logic [31:0]            start_reg, start_next;
    logic [31:0]            offset_reg, offset_next;
    logic [LENGTH_BITS-1:0] run_reg, run_next;
    logic [LINE_BITS-1:0]   line_reg, line_next;
    logic [47:0]            prefix_reg, prefix_next;

    logic is_ws, is_lf, is_alpha, is_digit, is_quote, is_slash, is_high;
    logic [LENGTH_BITS-1:0] run_inc;
    logic [47:0]            prefix_grow;
    stscan_pkg::kind_t      ident_kind;
    logic                   emit_a, emit_b, idle_proc;
    stscan_pkg::kind_t      kind_a;
    logic [LENGTH_BITS-1:0] len_a;

    assign is_ws    = (char_byte == 8'h20) || (char_byte == 8'h09) || (char_byte == 8'h0D);
    assign is_lf    = (char_byte == 8'h0A);
    assign is_alpha = (char_byte >= 8'h41 && char_byte <= 8'h5A) ||
                      (char_byte >= 8'h61 && char_byte <= 8'h7A) || (char_byte == 8'h5F);
    assign is_digit = (char_byte >= 8'h30 && char_byte <= 8'h39);
    assign is_quote = (char_byte == 8'h22);
    assign is_slash = (char_byte == 8'h2F);
    assign is_high  = char_byte[7];

    assign run_inc = (run_reg == '1) ? run_reg : run_reg + LENGTH_BITS'(1);

    always_comb begin
        prefix_grow = prefix_reg;
        for (int i = 0; i < 6; i++) begin
            if (run_reg == LENGTH_BITS'(i)) begin
                prefix_grow[8*i +: 8] = char_byte;
            end
        end
    end

    assign ident_kind = stscan_pkg::word_kind(prefix_reg, run_reg == LENGTH_BITS'(3),
                                              run_reg == LENGTH_BITS'(4),
                                              run_reg == LENGTH_BITS'(6));

    always_comb begin
        mode_next   = mode_reg;
        start_next  = start_reg;
        offset_next = offset_reg;
        run_next    = run_reg;
        line_next   = line_reg;
        prefix_next = prefix_reg;
        emit_a      = 1'b0;
        emit_b      = 1'b0;
        idle_proc   = 1'b0;
        kind_a      = stscan_pkg::KIND_IDENT;
        len_a       = run_reg;

        if (command) begin
            unique case (mode_reg)
                MODE_IDENT: begin
                    emit_a = 1'b1;
                    kind_a = ident_kind;
                end
                MODE_NUMBER: begin
                    emit_a = 1'b1;
                    kind_a = stscan_pkg::KIND_NUMBER;
                end
                MODE_STRING: begin
                    emit_a = 1'b1;
                    kind_a = stscan_pkg::KIND_ERROR;
                end
                MODE_SLASH: begin
                    emit_a = 1'b1;
                    kind_a = stscan_pkg::KIND_DIVIDE;
                    len_a  = LENGTH_BITS'(1);
                end
                default: ;
            endcase
            mode_next   = MODE_IDLE;
            run_next    = '0;
            prefix_next = '0;
        end else begin
            offset_next = offset_reg + 32'd1;
            unique case (mode_reg)
                MODE_IDENT: begin
                    if (is_alpha || is_digit) begin
                        run_next    = run_inc;
                        prefix_next = prefix_grow;
                    end else begin
                        emit_a    = 1'b1;
                        kind_a    = ident_kind;
                        idle_proc = 1'b1;
                    end
                end
                MODE_NUMBER: begin
                    if (is_digit) begin
                        run_next    = run_inc;
                        prefix_next = prefix_grow;
                    end else begin
                        emit_a    = 1'b1;
                        kind_a    = stscan_pkg::KIND_NUMBER;
                        idle_proc = 1'b1;
                    end
                end
                MODE_STRING: begin
                    run_next    = run_inc;
                    prefix_next = prefix_grow;
                    if (is_quote || is_high) begin
                        emit_a    = 1'b1;
                        kind_a    = stscan_pkg::KIND_STRING;
                        len_a     = run_inc;
                        mode_next = MODE_IDLE;
                    end
                end
                MODE_SLASH: begin
                    if (is_slash) begin
                        mode_next = MODE_COMMENT;
                    end else begin
                        emit_a    = 1'b1;
                        kind_a    = stscan_pkg::KIND_DIVIDE;
                        len_a     = LENGTH_BITS'(1);
                        idle_proc = 1'b1;
                    end
                end
                MODE_COMMENT: begin
                    idle_proc = is_lf;
                end
                default: begin
                    idle_proc = 1'b1;
                end
            endcase

            if (idle_proc) begin
                mode_next = MODE_IDLE;
                if (is_lf) begin
                    if (line_reg != '1) begin
                        line_next = line_reg + LINE_BITS'(1);
                    end
                end else if (is_alpha || is_digit || is_quote || is_slash) begin
                    start_next  = offset_reg;
                    run_next    = LENGTH_BITS'(1);
                    prefix_next = {40'd0, char_byte};
                    if (is_alpha) begin
                        mode_next = MODE_IDENT;
                    end else if (is_digit) begin
                        mode_next = MODE_NUMBER;
                    end else if (is_quote) begin
                        mode_next = MODE_STRING;
                    end else begin
                        mode_next = MODE_SLASH;
                    end
                end else if (!is_ws) begin
                    emit_b = 1'b1;
                end
            end
        end
    end

    assign push                = accept && (emit_a || emit_b);
    assign push_ctl.has_a      = emit_a;
    assign push_ctl.has_b      = emit_b;
    assign push_ctl.kind_a     = kind_a;
    assign push_ctl.kind_b     = stscan_pkg::single_kind(char_byte);
    assign push_start_a        = start_reg;
    assign push_start_b        = offset_reg;
    assign push_len_a          = len_a;
    assign push_line           = line_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            mode_reg   <= MODE_IDLE;
            start_reg  <= '0;
            offset_reg <= '0;
            run_reg    <= '0;
            line_reg   <= LINE_BITS'(1);
            prefix_reg <= '0;
        end else if (accept) begin
            mode_reg   <= mode_next;
            start_reg  <= start_next;
            offset_reg <= offset_next;
            run_reg    <= run_next;
            line_reg   <= line_next;
            prefix_reg <= prefix_next;
        end
    end

endmodule

FILE: rtl/stscan_fifo.sv
// ----------------------------------------------------------------------------
// stscan_fifo
// Short bundle queue between scanner and output stage.
// ----------------------------------------------------------------------------
module stscan_fifo #(
    parameter int DATA_W = 128
) (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              push,
    input  logic [DATA_W-1:0] push_data,
    input  logic              pop,
    output logic [DATA_W-1:0] head_data,
    output logic              empty,
    output logic              full
);

    localparam int PTR_W = stscan_pkg::QUEUE_PTR_W;

    logic [DATA_W-1:0] mem [stscan_pkg::QUEUE_DEPTH];
    logic [PTR_W-1:0]  wr_ptr_reg, rd_ptr_reg;
    logic [PTR_W:0]    count_reg;
    logic              do_push, do_pop;

    assign empty     = (count_reg == '0);
    assign full      = (count_reg == (PTR_W + 1)'(stscan_pkg::QUEUE_DEPTH));
    assign do_push   = push && !full;
    assign do_pop    = pop && !empty;
    assign head_data = mem[rd_ptr_reg];

    always_ff @(posedge aclk) begin
        if (do_push) begin
            mem[wr_ptr_reg] <= push_data;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            if (do_push) begin
                wr_ptr_reg <= wr_ptr_reg + PTR_W'(1);
            end
            if (do_pop) begin
                rd_ptr_reg <= rd_ptr_reg + PTR_W'(1);
            end
            if (do_push && !do_pop) begin
                count_reg <= count_reg + (PTR_W + 1)'(1);
            end else if (do_pop && !do_push) begin
                count_reg <= count_reg - (PTR_W + 1)'(1);
            end
        end
    end

endmodule

FILE: rtl/stscan_back.sv
// ----------------------------------------------------------------------------
// stscan_back
// Output stage: unpacks each bundle into one or two tokens and holds them in
// the result register until taken.
// ----------------------------------------------------------------------------
module stscan_back #(
    parameter int LENGTH_BITS = 16,
    parameter int LINE_BITS   = 24
) (
    input  logic                   aclk,
    input  logic                   aresetn,
    input  logic                   head_valid,
    input  stscan_pkg::tok_ctl_t   head_ctl,
    input  logic [31:0]            head_start_a,
    input  logic [31:0]            head_start_b,
    input  logic [LENGTH_BITS-1:0] head_len_a,
    input  logic [LINE_BITS-1:0]   head_line,
    output logic                   pop,
    output logic                   m_valid,
    input  logic                   m_ready,
    output logic [4:0]             m_token_kind,
    output logic [31:0]            m_start_offset,
    output logic [LENGTH_BITS-1:0] m_token_length,
    output logic [LINE_BITS-1:0]   m_line_number,
    output logic                   m_last_in_run
);

    logic                   valid_reg;
    logic                   second_reg;
    logic [4:0]             kind_reg;
    logic [31:0]            start_reg;
    logic [LENGTH_BITS-1:0] len_reg;
    logic [LINE_BITS-1:0]   line_reg;
    logic                   last_reg;

    logic load, take_a;

    assign load   = head_valid && (!valid_reg || m_ready);
    // slot A goes first when present; second_reg marks A already sent
    assign take_a = head_ctl.has_a && !second_reg;
    assign pop    = load && !(take_a && head_ctl.has_b);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg  <= 1'b0;
            second_reg <= 1'b0;
        end else begin
            if (load) begin
                valid_reg  <= 1'b1;
                second_reg <= take_a && head_ctl.has_b;
            end else if (m_ready) begin
                valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (load) begin
            line_reg <= head_line;
            last_reg <= !(take_a && head_ctl.has_b);
            if (take_a) begin
                kind_reg  <= head_ctl.kind_a;
                start_reg <= head_start_a;
                len_reg   <= head_len_a;
            end else begin
                kind_reg  <= head_ctl.kind_b;
                start_reg <= head_start_b;
                len_reg   <= LENGTH_BITS'(1);
            end
        end
    end

    assign m_valid        = valid_reg;
    assign m_token_kind   = kind_reg;
    assign m_start_offset = start_reg;
    assign m_token_length = len_reg;
    assign m_line_number  = line_reg;
    assign m_last_in_run  = last_reg;

endmodule

FILE: rtl/source_token_scanner_core.sv
// ----------------------------------------------------------------------------
// source_token_scanner_core
// Streaming byte scanner producing identifier, keyword, number, string,
// punctuator, operator and error tokens.
// ----------------------------------------------------------------------------
// One byte or end-of-input item is accepted per cycle whenever the four-entry
// bundle queue has room. Each item yields zero, one or two tokens, which leave
// the result port at one per cycle while m_ready is high, from a registered
// output stage; the two tokens of an item leave one after the other, and the
// sustained rate is set by that single result port. Tokens pass through the
// bundle queue and the result register. Tokens carry the line current when
// they are completed; end of input flushes the pending token (an open string
// becomes an error) and keeps offset and line count.
module source_token_scanner_core #(
    parameter int LENGTH_BITS = 16,
    parameter int LINE_BITS   = 24
) (
    input  logic                   aclk,
    input  logic                   aresetn,
    input  logic                   s_valid,
    output logic                   s_ready,
    input  logic                   s_command,
    input  logic [7:0]             s_char_byte,
    output logic                   m_valid,
    input  logic                   m_ready,
    output logic [4:0]             m_token_kind,
    output logic [31:0]            m_start_offset,
    output logic [LENGTH_BITS-1:0] m_token_length,
    output logic [LINE_BITS-1:0]   m_line_number,
    output logic                   m_last_in_run
);

    localparam int DATA_W = stscan_pkg::TOK_CTL_W + 64 + LENGTH_BITS + LINE_BITS;

    logic                   accept;
    logic                   push;
    stscan_pkg::tok_ctl_t   push_ctl;
    logic [31:0]            push_start_a, push_start_b;
    logic [LENGTH_BITS-1:0] push_len_a;
    logic [LINE_BITS-1:0]   push_line;

    logic [DATA_W-1:0]      head_data;
    logic                   q_empty, q_full, pop;
    stscan_pkg::tok_ctl_t   head_ctl;
    logic [31:0]            head_start_a, head_start_b;
    logic [LENGTH_BITS-1:0] head_len_a;
    logic [LINE_BITS-1:0]   head_line;

    assign s_ready = !q_full;
    assign accept  = s_valid && s_ready;

    stscan_front #(
        .LENGTH_BITS (LENGTH_BITS),
        .LINE_BITS   (LINE_BITS)
    ) u_front (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .accept       (accept),
        .command      (s_command),
        .char_byte    (s_char_byte),
        .push         (push),
        .push_ctl     (push_ctl),
        .push_start_a (push_start_a),
        .push_start_b (push_start_b),
        .push_len_a   (push_len_a),
        .push_line    (push_line)
    );

    stscan_fifo #(
        .DATA_W (DATA_W)
    ) u_fifo (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .push      (push),
        .push_data ({push_ctl, push_start_a, push_start_b, push_len_a, push_line}),
        .pop       (pop),
        .head_data (head_data),
        .empty     (q_empty),
        .full      (q_full)
    );

    assign {head_ctl, head_start_a, head_start_b, head_len_a, head_line} = head_data;

    stscan_back #(
        .LENGTH_BITS (LENGTH_BITS),
        .LINE_BITS   (LINE_BITS)
    ) u_back (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .head_valid     (!q_empty),
        .head_ctl       (head_ctl),
        .head_start_a   (head_start_a),
        .head_start_b   (head_start_b),
        .head_len_a     (head_len_a),
        .head_line      (head_line),
        .pop            (pop),
        .m_valid        (m_valid),
        .m_ready        (m_ready),
        .m_token_kind   (m_token_kind),
        .m_start_offset (m_start_offset),
        .m_token_length (m_token_length),
        .m_line_number  (m_line_number),
        .m_last_in_run  (m_last_in_run)
    );

endmodule

FILE: rtl/stscan_checker.sv
// ----------------------------------------------------------------------------
// stscan_checker
// Port-level checks on the result channel of the token scanner.
// ----------------------------------------------------------------------------
module stscan_checker #(
    parameter int LENGTH_BITS = 16,
    parameter int LINE_BITS   = 24
) (
    input logic                   aclk,
    input logic                   aresetn,
    input logic                   m_valid,
    input logic                   m_ready,
    input logic [4:0]             m_token_kind,
    input logic [LENGTH_BITS-1:0] m_token_length,
    input logic [LINE_BITS-1:0]   m_line_number,
    input logic                   m_last_in_run
);

    a_hold_valid : assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid)
        else $error("result dropped while stalled");

    a_kind_range : assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> m_token_kind <= stscan_pkg::KIND_ERROR)
        else $error("token kind out of range");

    a_len_nonzero : assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> m_token_length != '0)
        else $error("zero length token");

    a_line_nonzero : assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> m_line_number != '0)
        else $error("line number zero");

    a_pair_order : assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_ready && !m_last_in_run |=> m_valid)
        else $error("first of a token pair not followed by its partner");

endmodule

bind source_token_scanner_core stscan_checker #(
    .LENGTH_BITS (LENGTH_BITS),
    .LINE_BITS   (LINE_BITS)
) u_stscan_checker (
    .aclk           (aclk),
    .aresetn        (aresetn),
    .m_valid        (m_valid),
    .m_ready        (m_ready),
    .m_token_kind   (m_token_kind),
    .m_token_length (m_token_length),
    .m_line_number  (m_line_number),
    .m_last_in_run  (m_last_in_run)
);

FILE: tb/tb_source_token_scanner_core.sv
// ----------------------------------------------------------------------------
// tb_source_token_scanner_core
// Self-checking testbench for the streaming source token scanner.
// Bytes and end-of-input items are sent over the input handshake in random
// bursts. Every accepted item runs through a scanner model kept inside the
// testbench, which queues the tokens the item should produce. A receiver with
// its own stall pattern compares each token, field by field, with the oldest
// queued one. Directed tests cover keywords, slash and comment handling,
// strings and stray bytes; a back-pressure test and a long random run of
// well-formed fragments mixed with noise follow.
// ----------------------------------------------------------------------------
module tb_source_token_scanner_core;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int LENGTH_BITS  = 16;
    localparam int LINE_BITS    = 24;
    localparam int STALL_LIMIT  = 3000;
    localparam int DRAIN_CYCLES = 8;
    localparam int LONG_HOLD    = 400;
    localparam int RANDOM_ITEMS = 1600;
    localparam int REPORT_LIMIT = 40;

    localparam logic CMD_BYTE = 1'b0;
    localparam logic CMD_END  = 1'b1;

    localparam logic [7:0] CH_TAB   = 8'h09;
    localparam logic [7:0] CH_LF    = 8'h0A;
    localparam logic [7:0] CH_CR    = 8'h0D;
    localparam logic [7:0] CH_SPACE = 8'h20;
    localparam logic [7:0] CH_QUOTE = 8'h22;
    localparam logic [7:0] CH_SLASH = 8'h2F;

    localparam logic [15:0] LEN_MAX  = 16'hFFFF;
    localparam logic [23:0] LINE_MAX = 24'hFFFFFF;

    // keyword bytes, first byte in the low bits
    localparam logic [47:0] KEY_INT    = {24'd0, "t", "n", "i"};
    localparam logic [47:0] KEY_VOID   = {16'd0, "d", "i", "o", "v"};
    localparam logic [47:0] KEY_RET    = {"n", "r", "u", "t", "e", "r"};
    localparam logic [47:0] KEY_STR    = {"g", "n", "i", "r", "t", "s"};

    typedef enum logic [2:0] {
        MODE_IDLE, MODE_IDENT, MODE_NUMBER, MODE_STRING, MODE_SLASH, MODE_COMMENT
    } scan_mode_e;

    typedef struct {
        stscan_pkg::kind_t kind;
        logic [31:0]       start;
        logic [15:0]       token_len;
        logic [23:0]       line;
        logic              last_flag;
    } scanned_token_t;

    logic                   aclk        = 1'b0;
    logic                   aresetn     = 1'b0;
    logic                   s_valid     = 1'b0;
    logic                   s_command   = 1'b0;
    logic [7:0]             s_char_byte = 8'h00;
    logic                   m_ready     = 1'b0;
    logic                   s_ready;
    logic                   m_valid;
    logic [4:0]             m_token_kind;
    logic [31:0]            m_start_offset;
    logic [LENGTH_BITS-1:0] m_token_length;
    logic [LINE_BITS-1:0]   m_line_number;
    logic                   m_last_in_run;

    source_token_scanner_core #(
        .LENGTH_BITS(LENGTH_BITS),
        .LINE_BITS  (LINE_BITS)
    ) dut (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .s_valid       (s_valid),
        .s_ready       (s_ready),
        .s_command     (s_command),
        .s_char_byte   (s_char_byte),
        .m_valid       (m_valid),
        .m_ready       (m_ready),
        .m_token_kind  (m_token_kind),
        .m_start_offset(m_start_offset),
        .m_token_length(m_token_length),
        .m_line_number (m_line_number),
        .m_last_in_run (m_last_in_run)
    );

    always #5ns aclk = ~aclk;

    // scanner model state
    scan_mode_e     pred_mode;
    logic [31:0]    pred_start;
    logic [31:0]    pred_offset;
    logic [15:0]    pred_len;
    logic [23:0]    pred_line;
    logic [47:0]    pred_prefix;
    scanned_token_t step_tokens[$];
    scanned_token_t expected_tokens[$];

    int fail_count    = 0;
    int items_sent    = 0;
    int burst_left    = 0;
    bit gaps_on       = 1'b1;
    int hold_request  = 0;
    int hold_seen     = 0;
    int hold_left     = 0;
    int sink_tick     = 0;
    int stall_cycles  = 0;

    string keyword_words[4] = '{"int", "void", "return", "string"};
    string punct_chars      = "()[]{};:+-*%=&|^!";

    function automatic bit is_letter(logic [7:0] c);
        return (c >= "A" && c <= "Z") || (c >= "a" && c <= "z");
    endfunction

    function automatic bit is_digit_byte(logic [7:0] c);
        return c >= "0" && c <= "9";
    endfunction

    function automatic void reset_scanner_model();
        pred_mode   = MODE_IDLE;
        pred_start  = '0;
        pred_offset = '0;
        pred_len    = '0;
        pred_line   = 24'd1;
        pred_prefix = '0;
    endfunction

    function automatic void push_token(stscan_pkg::kind_t k, logic [31:0] st,
                                       logic [15:0] len);
        scanned_token_t t;
        t.kind      = k;
        t.start     = st;
        t.token_len = len;
        t.line      = pred_line;
        t.last_flag = 1'b0;
        step_tokens.push_back(t);
    endfunction

    function automatic stscan_pkg::kind_t keyword_of();
        if (pred_len == 16'd3 && pred_prefix == KEY_INT) return stscan_pkg::KIND_INT;
        if (pred_len == 16'd4 && pred_prefix == KEY_VOID) return stscan_pkg::KIND_VOID;
        if (pred_len == 16'd6 && pred_prefix == KEY_RET) return stscan_pkg::KIND_RETURN;
        if (pred_len == 16'd6 && pred_prefix == KEY_STR) return stscan_pkg::KIND_STRKW;
        return stscan_pkg::KIND_IDENT;
    endfunction

    function automatic void extend_token(logic [7:0] c);
        if (pred_len < 16'd6) begin
            pred_prefix = pred_prefix | (48'(c) << (8 * pred_len));
        end
        if (pred_len < LEN_MAX) begin
            pred_len = pred_len + 16'd1;
        end
    endfunction

    function automatic void open_token(scan_mode_e m, logic [7:0] c);
        pred_mode   = m;
        pred_start  = pred_offset;
        pred_len    = '0;
        pred_prefix = '0;
        extend_token(c);
    endfunction

    function automatic stscan_pkg::kind_t punct_kind(logic [7:0] c);
        case (c)
            "(":     return stscan_pkg::KIND_LPAREN;
            ")":     return stscan_pkg::KIND_RPAREN;
            "[":     return stscan_pkg::KIND_LBRACKET;
            "]":     return stscan_pkg::KIND_RBRACKET;
            "{":     return stscan_pkg::KIND_LBRACE;
            "}":     return stscan_pkg::KIND_RBRACE;
            ";":     return stscan_pkg::KIND_SEMI;
            ":":     return stscan_pkg::KIND_COLON;
            "+":     return stscan_pkg::KIND_PLUS;
            "-":     return stscan_pkg::KIND_MINUS;
            "*":     return stscan_pkg::KIND_STAR;
            "%":     return stscan_pkg::KIND_PERCENT;
            "=":     return stscan_pkg::KIND_ASSIGN;
            "&":     return stscan_pkg::KIND_AMP;
            "|":     return stscan_pkg::KIND_PIPE;
            "^":     return stscan_pkg::KIND_CARET;
            "!":     return stscan_pkg::KIND_BANG;
            default: return stscan_pkg::KIND_ERROR;
        endcase
    endfunction

    // byte seen with no token pending
    function automatic void scan_fresh(logic [7:0] c);
        pred_mode = MODE_IDLE;
        if (c == CH_SPACE || c == CH_TAB || c == CH_CR) begin
            return;
        end
        if (c == CH_LF) begin
            if (pred_line < LINE_MAX) pred_line = pred_line + 24'd1;
            return;
        end
        if (is_letter(c) || c == "_") begin
            open_token(MODE_IDENT, c);
        end else if (is_digit_byte(c)) begin
            open_token(MODE_NUMBER, c);
        end else if (c == CH_QUOTE) begin
            open_token(MODE_STRING, c);
        end else if (c == CH_SLASH) begin
            open_token(MODE_SLASH, c);
        end else begin
            push_token(punct_kind(c), pred_offset, 16'd1);
        end
    endfunction

    function automatic void predict_item(logic cmd, logic [7:0] c);
        scanned_token_t t;
        if (cmd == CMD_END) begin
            case (pred_mode)
                MODE_IDENT:  push_token(keyword_of(), pred_start, pred_len);
                MODE_NUMBER: push_token(stscan_pkg::KIND_NUMBER, pred_start, pred_len);
                MODE_STRING: push_token(stscan_pkg::KIND_ERROR, pred_start, pred_len);
                MODE_SLASH:  push_token(stscan_pkg::KIND_DIVIDE, pred_start, 16'd1);
                default: ;
            endcase
            pred_mode   = MODE_IDLE;
            pred_len    = '0;
            pred_prefix = '0;
        end else begin
            case (pred_mode)
                MODE_IDENT: begin
                    if (is_letter(c) || is_digit_byte(c) || c == "_") begin
                        extend_token(c);
                    end else begin
                        push_token(keyword_of(), pred_start, pred_len);
                        scan_fresh(c);
                    end
                end
                MODE_NUMBER: begin
                    if (is_digit_byte(c)) begin
                        extend_token(c);
                    end else begin
                        push_token(stscan_pkg::KIND_NUMBER, pred_start, pred_len);
                        scan_fresh(c);
                    end
                end
                MODE_STRING: begin
                    extend_token(c);
                    if (c == CH_QUOTE || c >= 8'd128) begin
                        push_token(stscan_pkg::KIND_STRING, pred_start, pred_len);
                        pred_mode = MODE_IDLE;
                    end
                end
                MODE_SLASH: begin
                    if (c == CH_SLASH) begin
                        pred_mode = MODE_COMMENT;
                    end else begin
                        push_token(stscan_pkg::KIND_DIVIDE, pred_start, 16'd1);
                        scan_fresh(c);
                    end
                end
                MODE_COMMENT: begin
                    if (c == CH_LF) scan_fresh(c);
                end
                default: scan_fresh(c);
            endcase
            pred_offset = pred_offset + 32'd1;
        end
        for (int i = 0; i < step_tokens.size(); i++) begin
            t = step_tokens[i];
            t.last_flag = (i == step_tokens.size() - 1);
            expected_tokens.push_back(t);
        end
        step_tokens.delete();
    endfunction

    function automatic void check_field(string field, logic [31:0] want, logic [31:0] got);
        if (want !== got) begin
            fail_count++;
            if (fail_count <= REPORT_LIMIT) begin
                $display("%0t: %s mismatch, expected %0d actual %0d", $time, field, want, got);
            end
        end
    endfunction

    function automatic void check_token();
        scanned_token_t t;
        if (expected_tokens.size() == 0) begin
            fail_count++;
            if (fail_count <= REPORT_LIMIT) begin
                $display("%0t: unexpected token, expected none actual kind %0d offset %0d",
                         $time, m_token_kind, m_start_offset);
            end
            return;
        end
        t = expected_tokens.pop_front();
        check_field("token_kind", 32'(t.kind), 32'(m_token_kind));
        check_field("start_offset", t.start, m_start_offset);
        check_field("token_length", 32'(t.token_len), 32'(m_token_length));
        check_field("line_number", 32'(t.line), 32'(m_line_number));
        check_field("last_in_run", 32'(t.last_flag), 32'(m_last_in_run));
    endfunction

    // receiver: checks tokens, stalls on a rotating pattern, long hold on request
    always @(posedge aclk) begin
        if (aresetn && m_valid && m_ready) begin
            check_token();
        end
        sink_tick <= sink_tick + 1;
        if (hold_request != hold_seen) begin
            hold_seen <= hold_request;
            hold_left <= LONG_HOLD;
            m_ready   <= 1'b0;
        end else if (hold_left != 0) begin
            hold_left <= hold_left - 1;
            m_ready   <= 1'b0;
        end else begin
            case ((sink_tick / 256) % 4)
                0:       m_ready <= 1'b1;
                1:       m_ready <= 1'($urandom_range(0, 1));
                2:       m_ready <= (sink_tick % 4 == 0);
                default: m_ready <= ($urandom_range(0, 7) != 0);
            endcase
        end
    end

    always @(posedge aclk) begin
        if (!aresetn || (s_valid && s_ready) || (m_valid && m_ready)) begin
            stall_cycles <= 0;
        end else begin
            stall_cycles <= stall_cycles + 1;
        end
        if (stall_cycles == STALL_LIMIT) begin
            $display("%0t: no item moved for %0d cycles", $time, STALL_LIMIT);
            $display("Some tests failed");
            $finish;
        end
    end

    task automatic send_item(input logic cmd, input logic [7:0] c);
        int gap;
        if (burst_left == 0) begin
            if (gaps_on) begin
                s_valid <= 1'b0;
                gap = ($urandom_range(0, 15) == 0) ? $urandom_range(10, 25)
                                                   : $urandom_range(1, 5);
                repeat (gap) @(posedge aclk);
            end
            burst_left = $urandom_range(1, 32);
        end
        burst_left--;
        s_valid     <= 1'b1;
        s_command   <= cmd;
        s_char_byte <= c;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
        predict_item(cmd, c);
        items_sent++;
    endtask

    task automatic send_text(input string txt);
        for (int i = 0; i < txt.len(); i++) begin
            send_item(CMD_BYTE, txt[i]);
        end
    endtask

    task automatic wait_drain();
        s_valid    <= 1'b0;
        burst_left = 0;
        while (expected_tokens.size() != 0) @(posedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);
    endtask

    function automatic logic [7:0] rand_lead_byte();
        int r;
        r = $urandom_range(0, 52);
        if (r == 52) return "_";
        if (r < 26) return 8'("A" + r);
        return 8'("a" + r - 26);
    endfunction

    function automatic logic [7:0] rand_word_byte();
        int r;
        r = $urandom_range(0, 9);
        if (r < 3) return 8'("0" + $urandom_range(0, 9));
        return rand_lead_byte();
    endfunction

    function automatic logic [7:0] rand_text_byte();
        logic [7:0] c;
        c = 8'($urandom_range(32, 126));
        return (c == CH_QUOTE) ? 8'("x") : c;
    endfunction

    task automatic send_fragment();
        logic [7:0] frag[$];
        int         pick;
        int         n;
        bit         end_after;
        string      word;
        end_after = 1'b0;
        pick      = $urandom_range(0, 99);
        if (pick < 20) begin
            if ($urandom_range(0, 2) == 0) begin
                word = keyword_words[$urandom_range(0, 3)];
                for (int i = 0; i < word.len(); i++) frag.push_back(word[i]);
                case ($urandom_range(0, 5))
                    1: void'(frag.pop_back());
                    2: frag.push_back(rand_word_byte());
                    3: frag[0] = frag[0] ^ 8'h20;
                    default: ;
                endcase
            end else begin
                n = $urandom_range(1, 9);
                frag.push_back(rand_lead_byte());
                for (int i = 1; i < n; i++) frag.push_back(rand_word_byte());
            end
        end else if (pick < 30) begin
            n = $urandom_range(1, 6);
            for (int i = 0; i < n; i++) frag.push_back(8'("0" + $urandom_range(0, 9)));
        end else if (pick < 40) begin
            frag.push_back(CH_QUOTE);
            n = $urandom_range(0, 6);
            for (int i = 0; i < n; i++) begin
                frag.push_back(($urandom_range(0, 7) == 0) ? CH_LF : rand_text_byte());
            end
            n = $urandom_range(0, 9);
            if (n < 7) frag.push_back(CH_QUOTE);
            else if (n < 9) frag.push_back(8'($urandom_range(128, 255)));
            else end_after = 1'b1;
        end else if (pick < 48) begin
            frag.push_back(CH_SLASH);
            frag.push_back(CH_SLASH);
            n = $urandom_range(0, 8);
            for (int i = 0; i < n; i++) begin
                frag.push_back(8'($urandom_range(0, 255)));
                if (frag[$] == CH_LF) frag[$] = "c";
            end
            if ($urandom_range(0, 5) == 0) end_after = 1'b1;
            else frag.push_back(CH_LF);
        end else if (pick < 63) begin
            frag.push_back(punct_chars[$urandom_range(0, punct_chars.len() - 1)]);
        end else if (pick < 78) begin
            case ($urandom_range(0, 3))
                0:       frag.push_back(CH_SPACE);
                1:       frag.push_back(CH_TAB);
                2:       frag.push_back(CH_CR);
                default: frag.push_back(CH_LF);
            endcase
        end else if (pick < 86) begin
            frag.push_back(8'($urandom_range(0, 255)));
        end else if (pick < 90) begin
            end_after = 1'b1;
        end else begin
            frag.push_back(CH_SLASH);
            frag.push_back(8'($urandom_range(0, 255)));
        end
        foreach (frag[i]) send_item(CMD_BYTE, frag[i]);
        if (end_after) send_item(CMD_END, 8'($urandom_range(0, 255)));
    endtask

    // keywords, a two-token step, number then identifier, flush by end of input
    task automatic test_keywords();
        send_text("int(void;return 90_");
        send_item(CMD_END, 8'hFF);
        wait_drain();
    endtask

    // held slash, divide then identifier, comment to end of line, slash flushed
    task automatic test_slash_comment();
        send_text("/x//c");
        send_item(CMD_BYTE, CH_LF);
        send_text("/");
        send_item(CMD_END, 8'h00);
        wait_drain();
    endtask

    // string closed by a high byte, open string at end of input, stray bytes
    task automatic test_strings_errors();
        send_item(CMD_BYTE, CH_QUOTE);
        send_item(CMD_BYTE, "a");
        send_item(CMD_BYTE, 8'hFF);
        send_item(CMD_BYTE, CH_QUOTE);
        send_item(CMD_BYTE, CH_LF);
        send_item(CMD_END, 8'h5A);
        send_item(CMD_BYTE, 8'h00);
        send_item(CMD_BYTE, 8'h80);
        wait_drain();
    endtask

    task automatic test_backpressure();
        gaps_on = 1'b0;
        hold_request <= hold_request + 1;
        for (int i = 0; i < 40; i++) begin
            send_item(CMD_BYTE, punct_chars[$urandom_range(0, punct_chars.len() - 1)]);
        end
        wait_drain();
        gaps_on = 1'b1;
    endtask

    task automatic test_random_stream();
        int first;
        int next_pause;
        first      = items_sent;
        next_pause = first + $urandom_range(100, 300);
        while (items_sent - first < RANDOM_ITEMS) begin
            send_fragment();
            if (items_sent >= next_pause) begin
                wait_drain();
                gaps_on    = ($urandom_range(0, 3) != 0);
                next_pause = items_sent + $urandom_range(100, 300);
            end
        end
        wait_drain();
    endtask

    initial begin
        reset_scanner_model();
        repeat (4) @(posedge aclk);
        aresetn <= 1'b1;
        test_keywords();
        test_slash_comment();
        test_strings_errors();
        test_backpressure();
        test_random_stream();
        wait_drain();
        if (expected_tokens.size() != 0) begin
            fail_count++;
            $display("%0t: %0d tokens never arrived, expected kind %0d actual none",
                     $time, expected_tokens.size(), expected_tokens[0].kind);
        end
        if (fail_count == 0) begin
            $display("All tests passed");
        end else begin
            $display("Some tests failed");
        end
        $finish;
    end

endmodule

FILE: files.f
rtl/stscan_pkg.sv
rtl/stscan_front.sv
rtl/stscan_fifo.sv
rtl/stscan_back.sv
rtl/source_token_scanner_core.sv
rtl/stscan_checker.sv
tb/tb_source_token_scanner_core.sv
